### hdl/rlpwe_pkg.sv
// ----------------------------------------------------------------------------
// rlpwe_pkg
// Shared types, codes and sizes for the RGB LED pulse-width encoder.
// ----------------------------------------------------------------------------
package rlpwe_pkg;

  localparam int MAX_PIXELS   = 1024;
  localparam int COUNT_W      = 11;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int WORD_W       = 24;
  localparam int SEG_IDX_W    = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  // segments per pixel: two per bit
  localparam logic [SEG_IDX_W-1:0] SEG_LAST_BIT = SEG_IDX_W'(2 * WORD_W - 1);
  localparam logic [SEG_IDX_W-1:0] SEG_LATCH    = SEG_IDX_W'(2 * WORD_W);

  localparam logic [COUNT_W-1:0] MAX_PIXELS_C = COUNT_W'(MAX_PIXELS);

  // result status codes
  localparam logic [1:0] ST_BIT   = 2'd0;
  localparam logic [1:0] ST_LATCH = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATCH     = 3'd4;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic        line_level;
    logic [15:0] duration;
    logic [1:0]  status;
    logic        final_segment;
  } seg_out_t;

  // classified work item handed from front to back
  typedef struct packed {
    logic              is_error;
    logic              last;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  zero_high;
    logic [7:0]  zero_low;
    logic [7:0]  one_high;
    logic [7:0]  one_low;
    logic [15:0] latch;
  } timing_t;

endpackage

### hdl/rlpwe_front.sv
// ----------------------------------------------------------------------------
// rlpwe_front
// Accepts pixel beats, tracks the frame pixel count and classifies each
// pixel as a send or a drop command for the back end.
// ----------------------------------------------------------------------------
module rlpwe_front import rlpwe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  pix_in_t in_data,
  output logic    push,
  output cmd_t    push_cmd,
  input  logic    queue_full
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               full_frame;

  assign in_stall   = queue_full;
  assign push       = in_valid && !queue_full;
  assign full_frame = (count_r >= MAX_PIXELS_C);

  assign push_cmd.is_error = full_frame;
  assign push_cmd.last     = in_data.last_pixel;
  assign push_cmd.word     = {in_data.green, in_data.red, in_data.blue};

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      priority if (in_data.last_pixel) begin
        count_nxt = '0;
      end else if (!full_frame) begin
        count_nxt = count_r + COUNT_W'(1);
      end else begin
        count_nxt = count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

### hdl/rlpwe_queue.sv
// ----------------------------------------------------------------------------
// rlpwe_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module rlpwe_queue import rlpwe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    unique case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### hdl/rlpwe_back.sv
// ----------------------------------------------------------------------------
// rlpwe_back
// Walks one command at a time through its segments and drives the
// registered result channel, one segment per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module rlpwe_back import rlpwe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  timing_t  timing,
  input  logic     head_valid,
  input  cmd_t     head_cmd,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_stall,
  output seg_out_t out_data
);

  cmd_t                 cmd_r;
  logic                 busy_r, busy_nxt;
  logic [SEG_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  seg_out_t             out_data_r;
  seg_out_t             seg;
  logic                 adv;
  logic                 emit;
  logic                 seg_final;
  logic [4:0]           bit_sel;
  logic                 bit_val;

  assign adv     = !out_valid_r || !out_stall;
  assign emit    = busy_r && adv;
  assign bit_sel = 5'(WORD_W - 1) - idx_r[SEG_IDX_W-1:1];
  assign bit_val = cmd_r.word[bit_sel];

  // segment for the current index; even index is the high half of a bit
  always_comb begin
    seg = '0;
    priority if (cmd_r.is_error) begin
      seg.line_level    = 1'b0;
      seg.duration      = '0;
      seg.status        = ST_ERROR;
      seg.final_segment = 1'b1;
    end else if (idx_r == SEG_LATCH) begin
      seg.line_level    = 1'b0;
      seg.duration      = timing.latch;
      seg.status        = ST_LATCH;
      seg.final_segment = 1'b1;
    end else begin
      seg.line_level = !idx_r[0];
      seg.status     = ST_BIT;
      unique case ({bit_val, idx_r[0]})
        2'b00:   seg.duration = {8'd0, timing.zero_high};
        2'b01:   seg.duration = {8'd0, timing.zero_low};
        2'b10:   seg.duration = {8'd0, timing.one_high};
        default: seg.duration = {8'd0, timing.one_low};
      endcase
      seg.final_segment = (idx_r == SEG_LAST_BIT) && !cmd_r.last;
    end
  end

  assign seg_final = seg.final_segment;
  assign pop       = head_valid && (!busy_r || (emit && seg_final));

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = busy_r;
    end
    priority if (pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (emit && seg_final) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + SEG_IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
    if (emit) begin
      out_data_r <= seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hdl/rgb_led_pulse_width_encoder.sv
// ----------------------------------------------------------------------------
// rgb_led_pulse_width_encoder
// Turns pixel beats into timed high/low line segments for serial RGB LEDs.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one pixel per beat, green,
// red, blue, plus last_pixel marking the end of a frame.
// Result channel (out_valid / out_stall / out_data): one segment per beat.
// A pixel gives 48 bit segments, MSB first in G, R, B order, high then low;
// a last pixel adds a low latch segment (status latch). A pixel past
// MAX_PIXELS in a frame gives a single error beat and is not sent.
// The back end emits one segment per cycle into its output register while
// out_stall is low, and back-to-back commands follow with no gap. From
// idle, an accepted pixel passes the queue, the back-end load and the
// output register before its first segment is valid.
// A two-entry queue decouples the front end, so pixels are taken while a
// segment waits at the output. When out_stall is high the output register
// holds and the back end waits; in_stall rises once the queue is full.
// Config (cfg_we / cfg_index / cfg_wdata) is to be written only while idle;
// the user must keep to this, the block itself does not enforce it.
// Reset: timings return to defaults, pixel count clears, queue empties.
// ----------------------------------------------------------------------------
module rgb_led_pulse_width_encoder import rlpwe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output seg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  timing_t timing_r, timing_nxt;
  logic    push;
  cmd_t    push_cmd;
  logic    queue_full;
  logic    pop;
  logic    head_valid;
  cmd_t    head_cmd;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZERO_HIGH: timing_nxt.zero_high = cfg_wdata[7:0];
        CFG_ZERO_LOW:  timing_nxt.zero_low  = cfg_wdata[7:0];
        CFG_ONE_HIGH:  timing_nxt.one_high  = cfg_wdata[7:0];
        CFG_ONE_LOW:   timing_nxt.one_low   = cfg_wdata[7:0];
        CFG_LATCH:     timing_nxt.latch     = cfg_wdata;
        default:       timing_nxt = timing_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.zero_high <= 8'd45;
      timing_r.zero_low  <= 8'd83;
      timing_r.one_high  <= 8'd90;
      timing_r.one_low   <= 8'd38;
      timing_r.latch     <= 16'd6400;
    end else begin
      timing_r <= timing_nxt;
    end
  end

  rlpwe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  rlpwe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rlpwe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .timing     (timing_r),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_latch_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_LATCH) |->
      !out_data.line_level && out_data.final_segment)
    else $error("latch segment must be low and final");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ERROR) |->
      !out_data.line_level && (out_data.duration == 16'd0) && out_data.final_segment)
    else $error("drop report malformed");

  a_high_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_BIT) && out_data.line_level |->
      !out_data.final_segment)
    else $error("high segment closed an item");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3))
    else $error("undefined status code");

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("back end popped an empty queue");

endmodule
